// ----- rtl/core/block_sparse_table_range_max_assert.svh -----
// assertion helpers for the range max block
`ifndef BLOCK_SPARSE_TABLE_RANGE_MAX_ASSERT_SVH
`define BLOCK_SPARSE_TABLE_RANGE_MAX_ASSERT_SVH

// same-cycle implication
`define BSTRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSTRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bstrm_pkg.sv -----
`default_nettype none
package bstrm_pkg;
	localparam int IDX_W = 10;
	localparam int VAL_W = 30;
	localparam int CNT_W = 11;
	localparam int BS_W = 4;
	localparam int BLK_W = 7;
	localparam int LVL_W = 3;
	localparam int MEM_DEPTH = 1024;
	localparam int MAX_COUNT = 1024;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic ST_OK = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [IDX_W-1:0] left_index;
		logic [IDX_W-1:0] right_index;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] max_value;
		logic             status;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic stale;
	} eng_stat_t;

	function automatic logic [VAL_W-1:0] vmax(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// floor log2 of the count, at least one
	function automatic logic [BS_W-1:0] block_size(input logic [CNT_W-1:0] c);
		logic [BS_W-1:0] r;
		r = BS_W'(1);
		for (int i = 1; i < CNT_W; i++) begin
			if (c[i]) r = BS_W'(i);
		end
		return r;
	endfunction

	function automatic logic [LVL_W-1:0] flog2_blk(input logic [BLK_W-1:0] v);
		logic [LVL_W-1:0] r;
		r = '0;
		for (int i = 1; i < BLK_W; i++) begin
			if (v[i]) r = LVL_W'(i);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/bstrm_div.sv -----
`default_nettype none
module bstrm_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [bstrm_pkg::IDX_W-1:0] a,
	input  wire logic [bstrm_pkg::IDX_W-1:0] b,
	input  wire logic [bstrm_pkg::BS_W-1:0]  d,
	output logic                           done,
	output logic [bstrm_pkg::IDX_W-1:0]    qa,
	output logic [bstrm_pkg::IDX_W-1:0]    qb
);
	import bstrm_pkg::*;

	logic             busy_q, done_q;
	logic [BS_W-1:0]  cnt_q;
	logic [IDX_W-1:0] na_q, nb_q;
	logic [BS_W-1:0]  ra_q, rb_q;
	logic [BS_W:0]    ta, tb;
	logic             ga, gb;

	assign ta = {ra_q, na_q[IDX_W-1]};
	assign tb = {rb_q, nb_q[IDX_W-1]};
	assign ga = ta >= {1'b0, d};
	assign gb = tb >= {1'b0, d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + BS_W'(1);
				if (cnt_q == BS_W'(IDX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			na_q <= a;
			nb_q <= b;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			na_q <= {na_q[IDX_W-2:0], ga};
			nb_q <= {nb_q[IDX_W-2:0], gb};
			ra_q <= ga ? BS_W'(ta - {1'b0, d}) : ta[BS_W-1:0];
			rb_q <= gb ? BS_W'(tb - {1'b0, d}) : tb[BS_W-1:0];
		end
	end

	assign done = done_q;
	assign qa = na_q;
	assign qb = nb_q;
endmodule
`default_nettype wire

// ----- rtl/core/bstrm_engine.sv -----
`default_nettype none
module bstrm_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire bstrm_pkg::req_t           req,
	input  wire logic [bstrm_pkg::CNT_W-1:0] count,
	input  wire logic                      cfg_wr,
	input  wire logic                      out_free,
	output logic                           emit,
	output bstrm_pkg::rsp_t                rsp,
	output bstrm_pkg::eng_stat_t           stat
);
	import bstrm_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PRE  = 4'd1;
	localparam logic [3:0] S_SUF  = 4'd2;
	localparam logic [3:0] S_LVL  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_DIVW = 4'd5;
	localparam logic [3:0] S_SCAN = 4'd6;
	localparam logic [3:0] S_TAB  = 4'd7;
	localparam logic [3:0] S_TABW = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	localparam int ST_AW = LVL_W + BLK_W;

	logic [3:0]       state_q;
	logic             stale_q, iss_q;
	logic [IDX_W-1:0] lo_q, hi_q, ri_q;
	logic [BS_W-1:0]  rj_q;
	logic             v_s1, rst_s1, bend_s1, last_s1, lv_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ST_AW-1:0] wa_s1;
	logic [VAL_W-1:0] run_q, res_q;
	logic             err_q;
	logic [BLK_W:0]   blk_q;
	logic [LVL_W-1:0] k_q;
	logic [BLK_W-1:0] li_q, bl_q, br_q;

	logic [VAL_W-1:0] elem_mem [MEM_DEPTH];
	logic [VAL_W-1:0] pre_mem [MEM_DEPTH];
	logic [VAL_W-1:0] suf_mem [MEM_DEPTH];
	logic [VAL_W-1:0] st_mem [MEM_DEPTH];
	logic [VAL_W-1:0] elem_rd_q, pre_rd_q, suf_rd_q, st_rd0_q, st_rd1_q;

	logic [BS_W-1:0]  bs, bs_m1;
	logic [IDX_W-1:0] cnt_m1;
	logic             elem_we, pre_we, suf_we, st_we;
	logic [ST_AW-1:0] st_wa, st_ra0, st_ra1;
	logic [VAL_W-1:0] st_wd, nrun, run_in;
	logic [BLK_W+1:0] len, lvl_end;
	logic [BLK_W-1:0] half, diff, mlen;
	logic [LVL_W-1:0] mk, k_m1;
	logic             lvl_go, mid;
	logic             div_start, div_done;
	logic [IDX_W-1:0] qa, qb;
	logic             lo_bad, hi_bad, pre_last, suf_last;

	assign bs = block_size(count);
	assign bs_m1 = bs - BS_W'(1);
	assign cnt_m1 = IDX_W'(count - CNT_W'(1));

	assign run_in = rst_s1 ? '0 : run_q;
	assign nrun = vmax(run_in, elem_rd_q);

	assign k_m1 = k_q - LVL_W'(1);
	assign len = (BLK_W+2)'(1) << k_q;
	assign half = BLK_W'(1) << k_m1;
	assign lvl_end = {2'b00, li_q} + len;
	assign lvl_go = lvl_end <= {1'b0, blk_q};

	assign diff = br_q - bl_q;
	assign mid = diff >= BLK_W'(2);
	assign mlen = diff - BLK_W'(1);
	assign mk = flog2_blk(mlen);

	assign lo_bad = {1'b0, req.left_index} >= count;
	assign hi_bad = {1'b0, req.right_index} >= count;
	assign pre_last = ri_q == cnt_m1;
	assign suf_last = ri_q == '0;

	assign elem_we = (state_q == S_IDLE) && start && (req.operation == OP_LOAD) && !lo_bad;
	assign pre_we = (state_q == S_PRE) && v_s1;
	assign suf_we = (state_q == S_SUF) && v_s1;
	assign div_start = state_q == S_DIV;

	always_comb begin
		st_we = 1'b0;
		st_wa = wa_s1;
		st_wd = vmax(st_rd0_q, st_rd1_q);
		if (pre_we && bend_s1) begin
			st_we = 1'b1;
			st_wa = {LVL_W'(0), blk_q[BLK_W-1:0]};
			st_wd = nrun;
		end else if (lv_s1) begin
			st_we = 1'b1;
		end
		if (state_q == S_LVL) begin
			st_ra0 = {k_m1, li_q};
			st_ra1 = {k_m1, BLK_W'(li_q + half)};
		end else begin
			st_ra0 = {mk, BLK_W'(bl_q + BLK_W'(1))};
			st_ra1 = {mk, BLK_W'(br_q - (BLK_W'(1) << mk))};
		end
	end

	always_ff @(posedge clk) begin
		if (elem_we) elem_mem[req.left_index] <= req.value;
		elem_rd_q <= elem_mem[ri_q];
	end

	always_ff @(posedge clk) begin
		if (pre_we) pre_mem[idx_s1] <= nrun;
		pre_rd_q <= pre_mem[hi_q];
	end

	always_ff @(posedge clk) begin
		if (suf_we) suf_mem[idx_s1] <= nrun;
		suf_rd_q <= suf_mem[lo_q];
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_wa] <= st_wd;
		st_rd0_q <= st_mem[st_ra0];
		st_rd1_q <= st_mem[st_ra1];
	end

	bstrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (lo_q),
		.b      (hi_q),
		.d      (bs),
		.done   (div_done),
		.qa     (qa),
		.qb     (qb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stale_q <= 1'b1;
			iss_q <= 1'b0;
			v_s1 <= 1'b0;
			lv_s1 <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			lv_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req.operation == OP_LOAD) begin
							if (lo_bad) begin
								err_q <= ST_RANGE;
								res_q <= '0;
								state_q <= S_DONE;
							end else begin
								stale_q <= 1'b1;
							end
						end else if (lo_bad || hi_bad) begin
							err_q <= ST_RANGE;
							res_q <= '0;
							state_q <= S_DONE;
						end else begin
							if (req.left_index > req.right_index) begin
								lo_q <= req.right_index;
								hi_q <= req.left_index;
							end else begin
								lo_q <= req.left_index;
								hi_q <= req.right_index;
							end
							if (stale_q) begin
								state_q <= S_PRE;
								ri_q <= '0;
								rj_q <= '0;
								iss_q <= 1'b1;
								blk_q <= '0;
							end else begin
								state_q <= S_DIV;
							end
						end
					end
				end
				S_PRE: begin
					if (iss_q) begin
						v_s1 <= 1'b1;
						idx_s1 <= ri_q;
						rst_s1 <= rj_q == '0;
						bend_s1 <= (rj_q == bs_m1) || pre_last;
						last_s1 <= pre_last;
						if (pre_last) begin
							iss_q <= 1'b0;
						end else begin
							ri_q <= ri_q + IDX_W'(1);
							rj_q <= (rj_q == bs_m1) ? '0 : rj_q + BS_W'(1);
						end
					end
					if (v_s1) begin
						run_q <= nrun;
						if (bend_s1) blk_q <= blk_q + (BLK_W+1)'(1);
						if (last_s1) begin
							state_q <= S_SUF;
							iss_q <= 1'b1;
						end
					end
				end
				S_SUF: begin
					if (iss_q) begin
						v_s1 <= 1'b1;
						idx_s1 <= ri_q;
						rst_s1 <= (rj_q == bs_m1) || pre_last;
						last_s1 <= suf_last;
						if (suf_last) begin
							iss_q <= 1'b0;
						end else begin
							ri_q <= ri_q - IDX_W'(1);
							rj_q <= (rj_q == '0) ? bs_m1 : rj_q - BS_W'(1);
						end
					end
					if (v_s1) begin
						run_q <= nrun;
						if (last_s1) begin
							state_q <= S_LVL;
							k_q <= LVL_W'(1);
							li_q <= '0;
						end
					end
				end
				S_LVL: begin
					if (lvl_go) begin
						lv_s1 <= 1'b1;
						wa_s1 <= {k_q, li_q};
						li_q <= li_q + BLK_W'(1);
					end else if ((len << 1) <= {2'b00, blk_q}) begin
						k_q <= k_q + LVL_W'(1);
						li_q <= '0;
					end else begin
						stale_q <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						bl_q <= qa[BLK_W-1:0];
						br_q <= qb[BLK_W-1:0];
						if (qa == qb) begin
							state_q <= S_SCAN;
							ri_q <= lo_q;
							iss_q <= 1'b1;
							res_q <= '0;
						end else begin
							state_q <= S_TAB;
						end
					end
				end
				S_SCAN: begin
					if (iss_q) begin
						v_s1 <= 1'b1;
						last_s1 <= ri_q == hi_q;
						if (ri_q == hi_q) begin
							iss_q <= 1'b0;
						end else begin
							ri_q <= ri_q + IDX_W'(1);
						end
					end
					if (v_s1) begin
						res_q <= vmax(res_q, elem_rd_q);
						if (last_s1) begin
							err_q <= ST_OK;
							state_q <= S_DONE;
						end
					end
				end
				S_TAB: begin
					state_q <= S_TABW;
				end
				S_TABW: begin
					res_q <= vmax(vmax(suf_rd_q, pre_rd_q),
						mid ? vmax(st_rd0_q, st_rd1_q) : '0);
					err_q <= ST_OK;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_wr) stale_q <= 1'b1;
		end
	end

	assign emit = (state_q == S_DONE) && out_free;
	assign rsp.max_value = res_q;
	assign rsp.status = err_q;
	assign stat.idle = state_q == S_IDLE;
	assign stat.stale = stale_q;
endmodule
`default_nettype wire

// ----- rtl/core/block_sparse_table_range_max.sv -----
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   bstrm_pkg::req_t
// rsp       out        rsp_valid/rsp_stall   bstrm_pkg::rsp_t
// cfg       in         cfg_valid/cfg_ready   element count, 11 bits
//
// a load is written straight from idle; a query runs the block divide
// (ten steps, one quotient bit a cycle), then the table reads or an in-block scan
// of up to ten elements. the first query after loads or a count write first
// rebuilds the tables: two passes over the element memory, one element a cycle,
// then one sparse table entry a cycle. reset clears control state only; the
// memories are not cleared. a result waiting behind rsp_stall holds the engine
// in its final state, and requests stay stalled until the engine is idle again.
`default_nettype none
module block_sparse_table_range_max (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire bstrm_pkg::req_t             req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output bstrm_pkg::rsp_t                  rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bstrm_pkg::CNT_W-1:0] cfg_data
);
	import bstrm_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             emit, out_free, start, cfg_wr;
	rsp_t             eng_rsp;
	eng_stat_t        eng_stat;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign req_stall = !eng_stat.idle;
	assign start = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(MAX_COUNT);
		end else if (cfg_wr) begin
			if (cfg_data == '0) begin
				count_q <= CNT_W'(1);
			end else if (cfg_data > CNT_W'(MAX_COUNT)) begin
				count_q <= CNT_W'(MAX_COUNT);
			end else begin
				count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) rsp_q <= eng_rsp;
	end

	bstrm_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.count    (count_q),
		.cfg_wr   (cfg_wr),
		.out_free (out_free),
		.emit     (emit),
		.rsp      (eng_rsp),
		.stat     (eng_stat)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`include "block_sparse_table_range_max_assert.svh"

	`BSTRM_ASSERT_NOW(a_emit_slot, emit, out_free, "result issued into a full output register")
	`BSTRM_ASSERT_NOW(a_err_zero, rsp_valid && (rsp.status == ST_RANGE), rsp.max_value == '0,
		"error result with nonzero value")
	`BSTRM_ASSERT_NEXT(a_cfg_stale, cfg_wr, eng_stat.stale, "count write did not mark tables stale")
	`BSTRM_ASSERT_NEXT(a_emit_idle, emit, eng_stat.idle, "engine not idle after result")
endmodule
`default_nettype wire
